### rtl/ubxt_pkg.sv
// ----------------------------------------------------------------------------
// ubxt_pkg
// Shared types and constants of the UBX frame tracker: request and status
// codes, framing constants and the job record passed from front to back.
// ----------------------------------------------------------------------------
package ubxt_pkg;

  // request codes of an input item
  localparam logic [1:0] REQ_TX_HDR  = 2'd0;
  localparam logic [1:0] REQ_TX_DATA = 2'd1;
  localparam logic [1:0] REQ_RX_BYTE = 2'd2;

  // receive status codes
  localparam logic [1:0] RX_FAILED       = 2'd0;
  localparam logic [1:0] RX_ACCEPTED     = 2'd1;
  localparam logic [1:0] RX_NOT_ACCEPTED = 2'd2;
  localparam logic [1:0] RX_OTHER        = 2'd3;

  // result kinds
  localparam logic OUT_TX_BYTE   = 1'b0;
  localparam logic OUT_RX_STATUS = 1'b1;

  // configuration register indexes
  localparam logic CFG_NAV_CLASS = 1'b0;
  localparam logic CFG_ACK_CLASS = 1'b1;

  // framing constants
  localparam logic [7:0] SYNC_ONE = 8'hb5;
  localparam logic [7:0] SYNC_TWO = 8'h62;
  localparam logic [15:0] POS_MAX = 16'hffff;
  localparam logic [15:0] MIN_FRAME_LAST = 16'd7;

  // one classified item: up to eight transmit bytes or one status
  typedef struct packed {
    logic            kind;
    logic [2:0]      cnt_m1;
    logic [7:0][7:0] bytes;
    logic [1:0]      status;
    logic [7:0]      cls;
    logic [7:0]      idt;
  } job_t;

  // one result item as it leaves the block
  typedef struct packed {
    logic       kind;
    logic [7:0] tx_byte;
    logic       last;
    logic [1:0] status;
    logic [7:0] cls;
    logic [7:0] idt;
  } result_t;

endpackage

### rtl/ubxt_front.sv
// ----------------------------------------------------------------------------
// ubxt_front
// Accepts input items in order, keeps the framing and checksum state of both
// directions and turns each item into at most one job for the back end.
// ----------------------------------------------------------------------------
module ubxt_front (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              accept_i,
  input  logic [1:0]        req_type_i,
  input  logic [7:0]        msg_class_i,
  input  logic [7:0]        msg_ident_i,
  input  logic [15:0]       payload_len_i,
  input  logic [7:0]        data_byte_i,
  input  logic              frame_end_i,
  input  logic              cfg_we_i,
  input  logic              cfg_addr_i,
  input  logic [7:0]        cfg_wdata_i,
  output logic              job_valid_o,
  output ubxt_pkg::job_t    job_o
);

  logic [7:0]  nav_class_q, ack_class_q;
  logic        pend_valid_q, pend_valid_d;
  logic [7:0]  pend_class_q, pend_class_d;
  logic [7:0]  pend_ident_q, pend_ident_d;
  logic [7:0]  tx_sum_a_q, tx_sum_a_d;
  logic [7:0]  tx_sum_b_q, tx_sum_b_d;
  logic [15:0] tx_rem_q, tx_rem_d;
  logic [15:0] rx_pos_q, rx_pos_d;
  logic [7:0]  rx_sum_a_q, rx_sum_a_d;
  logic [7:0]  rx_sum_b_q, rx_sum_b_d;
  logic [7:0]  rx_prev0_q, rx_prev0_d;
  logic [7:0]  rx_prev1_q, rx_prev1_d;
  logic [7:0]  rx_cls_q, rx_cls_d;
  logic [7:0]  rx_idt_q, rx_idt_d;
  logic [7:0]  rx_ack0_q, rx_ack0_d;
  logic [7:0]  rx_ack1_q, rx_ack1_d;

  // header checksum chain over class, id, length low and length high
  logic [7:0] ha1, ha2, ha3, ha4, hb2, hb3, hb4;
  logic [7:0] len_lo, len_hi;
  // payload checksum step
  logic [7:0] pa, pb;
  logic [15:0] rem_dec;
  // receive working values
  logic        rx_sum_on;
  logic [7:0]  ra, rb, cls_n, idt_n, ack0_n, ack1_n;
  logic [1:0]  status;

  assign len_lo = payload_len_i[7:0];
  assign len_hi = payload_len_i[15:8];
  assign ha1 = msg_class_i;
  assign ha2 = ha1 + msg_ident_i;
  assign hb2 = ha1 + ha2;
  assign ha3 = ha2 + len_lo;
  assign hb3 = hb2 + ha3;
  assign ha4 = ha3 + len_hi;
  assign hb4 = hb3 + ha4;

  assign pa      = tx_sum_a_q + data_byte_i;
  assign pb      = tx_sum_b_q + pa;
  assign rem_dec = tx_rem_q - 16'd1;

  assign rx_sum_on = (rx_pos_q >= 16'd4);
  assign ra     = rx_sum_on ? rx_sum_a_q + rx_prev1_q : rx_sum_a_q;
  assign rb     = rx_sum_on ? rx_sum_b_q + ra : rx_sum_b_q;
  assign cls_n  = (rx_pos_q == 16'd2) ? data_byte_i : rx_cls_q;
  assign idt_n  = (rx_pos_q == 16'd3) ? data_byte_i : rx_idt_q;
  assign ack0_n = (rx_pos_q == 16'd6) ? data_byte_i : rx_ack0_q;
  assign ack1_n = (rx_pos_q == 16'd7) ? data_byte_i : rx_ack1_q;

  // classify the item and work out the next state
  always_comb begin
    pend_valid_d = pend_valid_q;
    pend_class_d = pend_class_q;
    pend_ident_d = pend_ident_q;
    tx_sum_a_d   = tx_sum_a_q;
    tx_sum_b_d   = tx_sum_b_q;
    tx_rem_d     = tx_rem_q;
    rx_pos_d     = rx_pos_q;
    rx_sum_a_d   = rx_sum_a_q;
    rx_sum_b_d   = rx_sum_b_q;
    rx_prev0_d   = rx_prev0_q;
    rx_prev1_d   = rx_prev1_q;
    rx_cls_d     = rx_cls_q;
    rx_idt_d     = rx_idt_q;
    rx_ack0_d    = rx_ack0_q;
    rx_ack1_d    = rx_ack1_q;
    status       = ubxt_pkg::RX_FAILED;
    job_valid_o  = 1'b0;
    job_o        = '0;
    case (req_type_i)
      ubxt_pkg::REQ_TX_HDR: begin
        job_valid_o  = 1'b1;
        job_o.kind   = ubxt_pkg::OUT_TX_BYTE;
        job_o.bytes  = {hb4, ha4, len_hi, len_lo, msg_ident_i, msg_class_i,
                        ubxt_pkg::SYNC_TWO, ubxt_pkg::SYNC_ONE};
        job_o.cnt_m1 = (payload_len_i == 16'd0) ? 3'd7 : 3'd5;
        pend_valid_d = 1'b1;
        pend_class_d = msg_class_i;
        pend_ident_d = msg_ident_i;
        tx_sum_a_d   = ha4;
        tx_sum_b_d   = hb4;
        tx_rem_d     = payload_len_i;
      end
      ubxt_pkg::REQ_TX_DATA: begin
        if (tx_rem_q != 16'd0) begin
          job_valid_o  = 1'b1;
          job_o.kind   = ubxt_pkg::OUT_TX_BYTE;
          job_o.bytes  = {8'd0, 8'd0, 8'd0, 8'd0, 8'd0, pb, pa, data_byte_i};
          job_o.cnt_m1 = (rem_dec == 16'd0) ? 3'd2 : 3'd0;
          tx_sum_a_d   = pa;
          tx_sum_b_d   = pb;
          tx_rem_d     = rem_dec;
        end
      end
      ubxt_pkg::REQ_RX_BYTE: begin
        if (!frame_end_i) begin
          rx_sum_a_d = ra;
          rx_sum_b_d = rb;
          rx_cls_d   = cls_n;
          rx_idt_d   = idt_n;
          rx_ack0_d  = ack0_n;
          rx_ack1_d  = ack1_n;
          rx_prev1_d = rx_prev0_q;
          rx_prev0_d = data_byte_i;
          if (rx_pos_q != ubxt_pkg::POS_MAX) begin
            rx_pos_d = rx_pos_q + 16'd1;
          end
        end else begin
          // judge the finished frame
          if (rx_pos_q < ubxt_pkg::MIN_FRAME_LAST || ra != rx_prev0_q ||
              rb != data_byte_i) begin
            status = ubxt_pkg::RX_FAILED;
          end else if (cls_n == nav_class_q) begin
            status = ubxt_pkg::RX_ACCEPTED;
          end else if (cls_n == ack_class_q) begin
            if (pend_valid_q && pend_class_q == ack0_n && pend_ident_q == ack1_n) begin
              pend_valid_d = 1'b0;
              status = (idt_n != 8'd0) ? ubxt_pkg::RX_ACCEPTED
                                       : ubxt_pkg::RX_NOT_ACCEPTED;
            end else begin
              status = ubxt_pkg::RX_FAILED;
            end
          end else begin
            status = ubxt_pkg::RX_OTHER;
          end
          job_valid_o  = 1'b1;
          job_o.kind   = ubxt_pkg::OUT_RX_STATUS;
          job_o.cnt_m1 = 3'd0;
          job_o.status = status;
          job_o.cls    = cls_n;
          job_o.idt    = idt_n;
          // drop the frame state
          rx_pos_d   = '0;
          rx_sum_a_d = '0;
          rx_sum_b_d = '0;
          rx_prev0_d = '0;
          rx_prev1_d = '0;
          rx_cls_d   = '0;
          rx_idt_d   = '0;
          rx_ack0_d  = '0;
          rx_ack1_d  = '0;
        end
      end
      default: begin
        job_valid_o = 1'b0;
      end
    endcase
    if (!accept_i) begin
      job_valid_o = 1'b0;
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nav_class_q <= 8'd1;
      ack_class_q <= 8'd5;
    end else if (cfg_we_i) begin
      case (cfg_addr_i)
        ubxt_pkg::CFG_NAV_CLASS: nav_class_q <= cfg_wdata_i;
        ubxt_pkg::CFG_ACK_CLASS: ack_class_q <= cfg_wdata_i;
        default: nav_class_q <= nav_class_q;
      endcase
    end
  end

  // advance the framing state on each accepted item
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_valid_q <= 1'b0;
      pend_class_q <= '0;
      pend_ident_q <= '0;
      tx_sum_a_q   <= '0;
      tx_sum_b_q   <= '0;
      tx_rem_q     <= '0;
      rx_pos_q     <= '0;
      rx_sum_a_q   <= '0;
      rx_sum_b_q   <= '0;
      rx_prev0_q   <= '0;
      rx_prev1_q   <= '0;
      rx_cls_q     <= '0;
      rx_idt_q     <= '0;
      rx_ack0_q    <= '0;
      rx_ack1_q    <= '0;
    end else if (accept_i) begin
      pend_valid_q <= pend_valid_d;
      pend_class_q <= pend_class_d;
      pend_ident_q <= pend_ident_d;
      tx_sum_a_q   <= tx_sum_a_d;
      tx_sum_b_q   <= tx_sum_b_d;
      tx_rem_q     <= tx_rem_d;
      rx_pos_q     <= rx_pos_d;
      rx_sum_a_q   <= rx_sum_a_d;
      rx_sum_b_q   <= rx_sum_b_d;
      rx_prev0_q   <= rx_prev0_d;
      rx_prev1_q   <= rx_prev1_d;
      rx_cls_q     <= rx_cls_d;
      rx_idt_q     <= rx_idt_d;
      rx_ack0_q    <= rx_ack0_d;
      rx_ack1_q    <= rx_ack1_d;
    end
  end

endmodule

### rtl/ubxt_fifo.sv
// ----------------------------------------------------------------------------
// ubxt_fifo
// Short job queue between the front and the back end, held in registers.
// ----------------------------------------------------------------------------
module ubxt_fifo #(
  parameter int unsigned Depth = 4
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           wr_en_i,
  input  ubxt_pkg::job_t wr_data_i,
  input  logic           rd_en_i,
  output ubxt_pkg::job_t rd_data_o,
  output logic           full_o,
  output logic           empty_o
);

  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(Depth - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(Depth);

  ubxt_pkg::job_t mem_q [Depth];
  logic [AddrW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]  cnt_q;
  logic             do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // store the incoming job
  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // advance pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      if (do_wr) begin
        wr_ptr_q <= (wr_ptr_q == LastAddr) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_rd) begin
        rd_ptr_q <= (rd_ptr_q == LastAddr) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_wr && !do_rd) begin
        cnt_q <= cnt_q + 1'b1;
      end else if (do_rd && !do_wr) begin
        cnt_q <= cnt_q - 1'b1;
      end
    end
  end

endmodule

### rtl/ubxt_back.sv
// ----------------------------------------------------------------------------
// ubxt_back
// Expands the job at the head of the queue into result items, placed one per
// cycle while the receiver keeps popping, into an output register that it drains.
// ----------------------------------------------------------------------------
module ubxt_back (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              head_valid_i,
  input  ubxt_pkg::job_t    head_i,
  output logic              head_pop_o,
  input  logic              pop_i,
  output logic              out_valid_o,
  output ubxt_pkg::result_t out_o
);

  logic              out_valid_q;
  ubxt_pkg::result_t out_q, res_d;
  logic [2:0]        idx_q;
  logic              take, load, last;

  assign take = !out_valid_q || pop_i;
  assign load = take && head_valid_i;
  assign last = (idx_q == head_i.cnt_m1);
  assign head_pop_o = load && last;

  // build the next result from the head job
  always_comb begin
    res_d      = '0;
    res_d.kind = head_i.kind;
    res_d.last = last;
    if (head_i.kind == ubxt_pkg::OUT_RX_STATUS) begin
      res_d.status = head_i.status;
      res_d.cls    = head_i.cls;
      res_d.idt    = head_i.idt;
    end else begin
      res_d.tx_byte = head_i.bytes[idx_q];
    end
  end

  // hold the result until taken, step through the job
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      idx_q       <= '0;
    end else begin
      if (load) begin
        out_valid_q <= 1'b1;
        idx_q       <= last ? 3'd0 : idx_q + 3'd1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      out_q <= res_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

endmodule

### rtl/ubx_frame_tx_rx_ack_tracker.sv
// ----------------------------------------------------------------------------
// ubx_frame_tx_rx_ack_tracker
// UBX framer and checker with Fletcher-8 checksums and acknowledge tracking.
// ----------------------------------------------------------------------------
// Usage:
//   Input queue: drive an item on the request ports and raise push; it is
//   taken at a clock edge where full is low. One item per cycle is taken
//   while the job queue has room.
//   Output queue: while empty is low the oldest result sits on the result
//   ports; raise pop to take it. Results leave at one per cycle while pop is held.
//   A transmit header yields 6 or 8 results, a payload byte 1 or 3, the last
//   byte of a received frame one status; other items yield none.
//   With the job queue and output register empty, the first result of an item
//   is written into the job queue and then the output register before it shows.
//   Throughput: one item per cycle at the input; the output side drains at most
//   one result per cycle while pop is held, so header bursts back up into the
//   job queue (JobDepth entries) and then raise full.
//   A stalled receiver (pop low) holds the result steady; the front keeps
//   taking items until the queue fills.
//   Reset clears all framing and acknowledge state and restores the class
//   registers to 1 (navigation) and 5 (acknowledge).
//   Configuration: cfg_we_i with cfg_addr_i 0 or 1 writes the class codes.
// ----------------------------------------------------------------------------
module ubx_frame_tx_rx_ack_tracker #(
  parameter int unsigned JobDepth = 4
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [1:0]  req_type_i,
  input  logic [7:0]  msg_class_i,
  input  logic [7:0]  msg_ident_i,
  input  logic [15:0] payload_len_i,
  input  logic [7:0]  data_byte_i,
  input  logic        frame_end_i,
  output logic        empty,
  input  logic        pop,
  output logic        out_kind_o,
  output logic [7:0]  tx_byte_o,
  output logic        run_last_o,
  output logic [1:0]  rx_status_o,
  output logic [7:0]  rx_class_o,
  output logic [7:0]  rx_ident_o,
  input  logic        cfg_we_i,
  input  logic        cfg_addr_i,
  input  logic [7:0]  cfg_wdata_i
);

  logic              accept, job_valid, fifo_empty, head_pop, out_valid;
  ubxt_pkg::job_t    job, head;
  ubxt_pkg::result_t res;

  assign accept = push && !full;

  ubxt_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (accept),
    .req_type_i    (req_type_i),
    .msg_class_i   (msg_class_i),
    .msg_ident_i   (msg_ident_i),
    .payload_len_i (payload_len_i),
    .data_byte_i   (data_byte_i),
    .frame_end_i   (frame_end_i),
    .cfg_we_i      (cfg_we_i),
    .cfg_addr_i    (cfg_addr_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .job_valid_o   (job_valid),
    .job_o         (job)
  );

  ubxt_fifo #(
    .Depth (JobDepth)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (job_valid),
    .wr_data_i (job),
    .rd_en_i   (head_pop),
    .rd_data_o (head),
    .full_o    (full),
    .empty_o   (fifo_empty)
  );

  ubxt_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .head_valid_i (!fifo_empty),
    .head_i       (head),
    .head_pop_o   (head_pop),
    .pop_i        (pop),
    .out_valid_o  (out_valid),
    .out_o        (res)
  );

  assign empty       = !out_valid;
  assign out_kind_o  = res.kind;
  assign tx_byte_o   = res.tx_byte;
  assign run_last_o  = res.last;
  assign rx_status_o = res.status;
  assign rx_class_o  = res.cls;
  assign rx_ident_o  = res.idt;

endmodule
